FILE: design/i2c_master_status_sequencer_macros.svh
// assertion macros for the sequencer top level
`ifndef I2C_MASTER_STATUS_SEQUENCER_MACROS_SVH
`define I2C_MASTER_STATUS_SEQUENCER_MACROS_SVH

// same-cycle implication, checked outside reset
`define I2CMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define I2CMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types, sizes and codes shared by the I2C master status sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    localparam int TX_DEPTH  = 32;
    localparam int TX_ADDR_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int TX_CNT_W  = $clog2(TX_DEPTH + 1);
    localparam int LEN_W     = 6;
    localparam int CMP_W     = (TX_CNT_W > LEN_W) ? TX_CNT_W : LEN_W;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;
    localparam int ITEM_W    = 47;
    localparam int RESULT_W  = 33;

    // item kinds carried on s_tuser
    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_LOAD   = 2'd1;
    localparam logic [1:0] MODE_STATUS = 2'd2;

    // controller status codes
    localparam logic [7:0] ST_BUS_ERROR    = 8'h00;
    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_RESTART      = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK     = 8'h18;
    localparam logic [7:0] ST_SLAW_NACK    = 8'h20;
    localparam logic [7:0] ST_TXDATA_ACK   = 8'h28;
    localparam logic [7:0] ST_TXDATA_NACK  = 8'h30;
    localparam logic [7:0] ST_ARB_LOST     = 8'h38;
    localparam logic [7:0] ST_SLAR_ACK     = 8'h40;
    localparam logic [7:0] ST_SLAR_NACK    = 8'h48;
    localparam logic [7:0] ST_RXDATA_ACK   = 8'h50;
    localparam logic [7:0] ST_RXDATA_NACK  = 8'h58;

    // bit positions of the result word used by checks
    localparam int RES_CMD_LSB  = 0;
    localparam int RES_CMD_MSB  = 30;
    localparam int RES_BUSY_BIT = 31;
    localparam int RES_CODE_BIT = 32;
    localparam int RES_START_BIT = 0;

    // packed with the first field in the highest bits
    typedef struct packed {
        logic [7:0]       rx_data;
        logic [7:0]       status_code;
        logic [7:0]       tx_byte;
        logic [7:0]       rx_length;
        logic [LEN_W-1:0] tx_length;
        logic             write_then_read;
        logic             read_not_write;
        logic [6:0]       slave_address;
    } item_t;

    typedef struct packed {
        logic       result_code;
        logic       busy_res;
        logic [7:0] rx_index;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic [7:0] data_write_byte;
        logic       data_write_valid;
        logic       clear_interrupt;
        logic       clear_ack;
        logic       set_ack;
        logic       set_stop;
        logic       set_start;
    } result_t;

    typedef struct packed {
        logic                 we;
        logic [TX_ADDR_W-1:0] waddr;
        logic [7:0]           wdata;
        logic [TX_ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage

FILE: design/i2cms_tx_ram.sv
// ----------------------------------------------------------------------------
// i2cms_tx_ram
// Transmit byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module i2cms_tx_ram (
    input  logic                clk,
    input  i2cms_pkg::ram_req_t req,
    output logic [7:0]          rdata
);
    import i2cms_pkg::*;

    logic [7:0] store_reg [TX_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            store_reg[req.waddr] <= req.wdata;
        end
    end

    // write-through so a byte loaded into the entry being read shows at once
    always_ff @(posedge clk)
    begin
        if (req.we && (req.waddr == req.raddr))
        begin
            rdata_reg <= req.wdata;
        end
        else
        begin
            rdata_reg <= store_reg[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/i2cms_ctrl.sv
// ----------------------------------------------------------------------------
// i2cms_ctrl
// Transfer state and per-word decision: start requests, buffer loads and
// controller status events, with the store read kept one entry ahead.
// ----------------------------------------------------------------------------
module i2cms_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [1:0]          mode,
    input  i2cms_pkg::item_t    item,
    input  logic [7:0]          rdata,
    output i2cms_pkg::ram_req_t ram_req,
    output i2cms_pkg::result_t  result
);
    import i2cms_pkg::*;

    logic [TX_CNT_W-1:0] tx_fill_reg, tx_fill_next;
    logic [TX_CNT_W-1:0] tx_position_reg, tx_position_next;
    logic [TX_CNT_W-1:0] tx_total_reg, tx_total_next;
    logic [7:0]          rx_count_reg, rx_count_next;
    logic [7:0]          rx_total_reg, rx_total_next;
    logic [6:0]          target_address_reg, target_address_next;
    logic                reading_reg, reading_next;
    logic                hold_bus_reg, hold_bus_next;
    logic                busy_flag_reg, busy_flag_next;
    logic                outcome_reg, outcome_next;

    logic [CMP_W-1:0]    len_ext;
    logic [CMP_W-1:0]    total_clip;
    logic [8:0]          rx_after_inc;
    logic                load_ok;
    result_t             res;

    assign len_ext    = CMP_W'(item.tx_length);
    assign total_clip = (len_ext > CMP_W'(TX_DEPTH)) ? CMP_W'(TX_DEPTH) : len_ext;
    assign load_ok    = (tx_fill_reg < TX_CNT_W'(TX_DEPTH));

    always_comb
    begin
        tx_fill_next        = tx_fill_reg;
        tx_position_next    = tx_position_reg;
        tx_total_next       = tx_total_reg;
        rx_count_next       = rx_count_reg;
        rx_total_next       = rx_total_reg;
        target_address_next = target_address_reg;
        reading_next        = reading_reg;
        hold_bus_next       = hold_bus_reg;
        busy_flag_next      = busy_flag_reg;
        outcome_next        = outcome_reg;
        rx_after_inc        = 9'd0;
        res                 = '0;

        case (mode)
            MODE_START:
            begin
                target_address_next = item.slave_address;
                hold_bus_next       = item.write_then_read;
                reading_next        = item.write_then_read ? 1'b0 : item.read_not_write;
                tx_total_next       = total_clip[TX_CNT_W-1:0];
                rx_total_next       = item.rx_length;
                outcome_next        = 1'b0;
                busy_flag_next      = 1'b0;
                tx_fill_next        = '0;
                res.set_start       = 1'b1;
            end
            MODE_LOAD:
            begin
                if (load_ok)
                begin
                    tx_fill_next = tx_fill_reg + 1'b1;
                end
            end
            MODE_STATUS:
            begin
                // phase-ending codes share the end-of-phase commands below
                case (item.status_code)
                    ST_BUS_ERROR:
                    begin
                        res.set_stop        = 1'b1;
                        res.set_ack         = 1'b1;
                        res.clear_interrupt = 1'b1;
                    end
                    ST_START, ST_RESTART:
                    begin
                        if (item.status_code == ST_START)
                        begin
                            busy_flag_next = 1'b1;
                        end
                        res.data_write_valid = 1'b1;
                        res.data_write_byte  = {target_address_reg, reading_reg};
                        res.set_ack          = 1'b1;
                        res.clear_interrupt  = 1'b1;
                        tx_position_next     = '0;
                        rx_count_next        = 8'd0;
                    end
                    ST_SLAW_ACK, ST_TXDATA_ACK:
                    begin
                        res.set_ack         = 1'b1;
                        res.clear_interrupt = 1'b1;
                        if ((tx_position_reg >= tx_total_reg) ||
                            (tx_position_reg >= TX_CNT_W'(TX_DEPTH)))
                        begin
                            if (!hold_bus_reg)
                            begin
                                res.set_stop   = 1'b1;
                                busy_flag_next = 1'b0;
                            end
                            else
                            begin
                                res.set_start = 1'b1;
                                reading_next  = 1'b1;
                                hold_bus_next = 1'b0;
                            end
                        end
                        else
                        begin
                            res.data_write_valid = 1'b1;
                            res.data_write_byte  = rdata;
                            tx_position_next     = tx_position_reg + 1'b1;
                        end
                    end
                    ST_SLAW_NACK, ST_TXDATA_NACK, ST_SLAR_NACK:
                    begin
                        outcome_next        = 1'b1;
                        res.set_ack         = 1'b1;
                        res.clear_interrupt = 1'b1;
                        if (!hold_bus_reg)
                        begin
                            res.set_stop   = 1'b1;
                            busy_flag_next = 1'b0;
                        end
                        else
                        begin
                            res.set_start = 1'b1;
                            reading_next  = 1'b1;
                            hold_bus_next = 1'b0;
                        end
                    end
                    ST_ARB_LOST:
                    begin
                        res.set_start       = 1'b1;
                        res.set_ack         = 1'b1;
                        res.clear_interrupt = 1'b1;
                        outcome_next        = 1'b1;
                    end
                    ST_SLAR_ACK:
                    begin
                        if (rx_total_reg <= 8'd1)
                        begin
                            res.clear_ack = 1'b1;
                        end
                        else
                        begin
                            res.set_ack = 1'b1;
                        end
                        res.clear_interrupt = 1'b1;
                    end
                    ST_RXDATA_ACK, ST_RXDATA_NACK:
                    begin
                        if (rx_count_reg < rx_total_reg)
                        begin
                            res.rx_valid = 1'b1;
                            res.rx_byte  = item.rx_data;
                            res.rx_index = rx_count_reg;
                        end
                        if (rx_count_reg != 8'd255)
                        begin
                            rx_count_next = rx_count_reg + 8'd1;
                        end
                        res.clear_interrupt = 1'b1;
                        if (item.status_code == ST_RXDATA_ACK)
                        begin
                            // nack the byte that will be the last one wanted
                            rx_after_inc = {1'b0, rx_count_next} + 9'd1;
                            if (rx_after_inc >= {1'b0, rx_total_reg})
                            begin
                                res.clear_ack = 1'b1;
                            end
                            else
                            begin
                                res.set_ack = 1'b1;
                            end
                        end
                        else
                        begin
                            res.set_ack = 1'b1;
                            if (!hold_bus_reg)
                            begin
                                res.set_stop   = 1'b1;
                                busy_flag_next = 1'b0;
                            end
                            else
                            begin
                                res.set_start = 1'b1;
                                reading_next  = 1'b1;
                                hold_bus_next = 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        res.busy_res    = busy_flag_next;
        res.result_code = outcome_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_fill_reg        <= '0;
            tx_position_reg    <= '0;
            tx_total_reg       <= '0;
            rx_count_reg       <= 8'd0;
            rx_total_reg       <= 8'd0;
            target_address_reg <= 7'd0;
            reading_reg        <= 1'b0;
            hold_bus_reg       <= 1'b0;
            busy_flag_reg      <= 1'b0;
            outcome_reg        <= 1'b0;
        end
        else if (accept)
        begin
            tx_fill_reg        <= tx_fill_next;
            tx_position_reg    <= tx_position_next;
            tx_total_reg       <= tx_total_next;
            rx_count_reg       <= rx_count_next;
            rx_total_reg       <= rx_total_next;
            target_address_reg <= target_address_next;
            reading_reg        <= reading_next;
            hold_bus_reg       <= hold_bus_next;
            busy_flag_reg      <= busy_flag_next;
            outcome_reg        <= outcome_next;
        end
    end

    // the store is read every cycle at the position the next word will use
    always_comb
    begin
        ram_req.we    = accept && (mode == MODE_LOAD) && load_ok;
        ram_req.waddr = tx_fill_reg[TX_ADDR_W-1:0];
        ram_req.wdata = item.tx_byte;
        ram_req.raddr = accept ? tx_position_next[TX_ADDR_W-1:0]
                               : tx_position_reg[TX_ADDR_W-1:0];
    end

    assign result = res;

endmodule

FILE: design/i2c_master_status_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_status_sequencer
// I2C master transfer sequencer: turns start requests, transmit byte loads
// and controller status events into controller commands and received bytes.
//
//   channel  dir  words                              handshake
//   s_*      in   start / load / status (tuser=mode) s_tvalid & s_tready
//   m_*      out  one command/result word per input  m_tvalid & m_tready
//
// One input word is taken per cycle unless the output stalls; its result is
// registered and shows the cycle after acceptance. The transmit store is read
// ahead at the current send position, so a byte is ready when the ack status comes.
// Reset clears all control state; the store itself is not cleared.
// While a result waits unaccepted, s_tready follows m_tready.
// ----------------------------------------------------------------------------
module i2c_master_status_sequencer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // slave_address, read_not_write, write_then_read, tx_length, rx_length,
    // tx_byte, status_code, rx_data, zero pad
    input  logic [i2cms_pkg::S_TDATA_W-1:0] s_tdata,
    // mode
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // set_start, set_stop, set_ack, clear_ack, clear_interrupt,
    // data_write_valid, data_write_byte, rx_valid, rx_byte, rx_index,
    // busy_res, result_code, zero pad
    output logic [i2cms_pkg::M_TDATA_W-1:0] m_tdata
);
    import i2cms_pkg::*;

    `include "i2c_master_status_sequencer_macros.svh"

    logic                 accept;
    item_t                item;
    ram_req_t             ram_req;
    logic [7:0]           rdata;
    result_t              result;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign item     = s_tdata[ITEM_W-1:0];

    i2cms_tx_ram u_tx_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (rdata)
    );

    i2cms_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .mode    (s_tuser),
        .item    (item),
        .rdata   (rdata),
        .ram_req (ram_req),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (accept)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= {{(M_TDATA_W - RESULT_W){1'b0}}, result};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a stalled input means a result is still waiting downstream
    `I2CMS_ASSERT_NOW(a_stall_has_cause, !s_tready, m_tvalid && !m_tready,
        "input stalled with no pending result")

    // a start request answers with a start command, idle and clear outcome
    `I2CMS_ASSERT_NEXT(a_start_word, accept && (s_tuser == MODE_START),
        m_tvalid && m_tdata[RES_START_BIT] && !m_tdata[RES_BUSY_BIT] &&
        !m_tdata[RES_CODE_BIT], "start request result wrong")

    // a buffer load issues no controller command
    `I2CMS_ASSERT_NEXT(a_load_silent, accept && (s_tuser == MODE_LOAD),
        m_tvalid && (m_tdata[RES_CMD_MSB:RES_CMD_LSB] == '0),
        "buffer load produced a command")

    // a data register write and a received byte never share a word
    `I2CMS_ASSERT_NOW(a_tx_rx_exclusive, m_tvalid,
        !(m_tdata[5] && m_tdata[14]), "data write and rx byte in one word")

endmodule

FILE: tb/tb_i2c_master_status_sequencer.sv
// ----------------------------------------------------------------------------
// tb_i2c_master_status_sequencer
// Self-checking bench for the I2C master status sequencer. A short table of
// directed words runs first, then well-formed write, read and write-then-read
// transfers mixed with noise words. Every result word is checked field by
// field against an in-bench transfer predictor, or against a typed expected
// word for some directed rows, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb_i2c_master_status_sequencer;
    import i2cms_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    i2c_master_status_sequencer DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    typedef struct {
        logic [1:0] mode;
        item_t      it;
        bit         typed;
        result_t    want;
    } stim_row_t;

    // transfer predictor state
    logic [7:0]          buf_bytes [TX_DEPTH];
    bit                  byte_seen [TX_DEPTH];
    logic [TX_CNT_W-1:0] buf_fill    = '0;
    logic [TX_CNT_W-1:0] send_pos    = '0;
    logic [TX_CNT_W-1:0] send_total  = '0;
    logic [7:0]          rcv_count   = '0;
    logic [7:0]          rcv_total   = '0;
    logic [6:0]          addr_q      = '0;
    logic                rd_dir      = 1'b0;
    logic                keep_bus    = 1'b0;
    logic                in_transfer = 1'b0;
    logic                failed      = 1'b0;

    result_t   expected_q [$];
    stim_row_t dir_rows [$];

    int err_count = 0;
    int n_taken   = 0;
    int n_results = 0;
    int n_rx      = 0;
    int n_nack    = 0;
    int hold_req  = 0;
    int hold_left = 0;
    bit src_calm  = 1'b0;
    bit sink_calm = 1'b0;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void close_phase(inout result_t r);
        r.set_ack = 1'b1;
        r.clear_interrupt = 1'b1;
        if (!keep_bus)
        begin
            r.set_stop = 1'b1;
            in_transfer = 1'b0;
        end
        else
        begin
            // repeated start into the read phase
            r.set_start = 1'b1;
            rd_dir = 1'b1;
            keep_bus = 1'b0;
        end
    endfunction

    function automatic void take_rx(inout result_t r, input logic [7:0] d);
        if (rcv_count < rcv_total)
        begin
            r.rx_valid = 1'b1;
            r.rx_byte = d;
            r.rx_index = rcv_count;
        end
        if (rcv_count != 8'hFF)
            rcv_count = rcv_count + 8'd1;
    endfunction

    function automatic bit is_known_code(input logic [7:0] code);
        case (code)
            ST_BUS_ERROR, ST_START, ST_RESTART, ST_SLAW_ACK, ST_SLAW_NACK,
            ST_TXDATA_ACK, ST_TXDATA_NACK, ST_ARB_LOST, ST_SLAR_ACK,
            ST_SLAR_NACK, ST_RXDATA_ACK, ST_RXDATA_NACK: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic result_t predict_word(input logic [1:0] mode, input item_t it);
        result_t r;
        r = '0;
        case (mode)
            MODE_START:
            begin
                addr_q = it.slave_address;
                keep_bus = it.write_then_read;
                rd_dir = it.write_then_read ? 1'b0 : it.read_not_write;
                send_total = (it.tx_length > TX_DEPTH) ? TX_DEPTH[TX_CNT_W-1:0] : it.tx_length;
                rcv_total = it.rx_length;
                failed = 1'b0;
                in_transfer = 1'b0;
                buf_fill = '0;
                r.set_start = 1'b1;
            end
            MODE_LOAD:
            begin
                if (buf_fill < TX_DEPTH)
                begin
                    buf_bytes[buf_fill[TX_ADDR_W-1:0]] = it.tx_byte;
                    byte_seen[buf_fill[TX_ADDR_W-1:0]] = 1'b1;
                    buf_fill = buf_fill + 1'b1;
                end
            end
            MODE_STATUS:
            begin
                case (it.status_code)
                    ST_BUS_ERROR:
                    begin
                        r.set_stop = 1'b1;
                        r.set_ack = 1'b1;
                        r.clear_interrupt = 1'b1;
                    end
                    ST_START, ST_RESTART:
                    begin
                        if (it.status_code == ST_START)
                            in_transfer = 1'b1;
                        r.data_write_valid = 1'b1;
                        r.data_write_byte = {addr_q, rd_dir};
                        r.set_ack = 1'b1;
                        r.clear_interrupt = 1'b1;
                        send_pos = '0;
                        rcv_count = '0;
                    end
                    ST_SLAW_ACK, ST_TXDATA_ACK:
                    begin
                        if (send_pos >= send_total)
                            close_phase(r);
                        else
                        begin
                            r.data_write_valid = 1'b1;
                            r.data_write_byte = buf_bytes[send_pos[TX_ADDR_W-1:0]];
                            r.set_ack = 1'b1;
                            r.clear_interrupt = 1'b1;
                            send_pos = send_pos + 1'b1;
                        end
                    end
                    ST_SLAW_NACK, ST_TXDATA_NACK, ST_SLAR_NACK:
                    begin
                        failed = 1'b1;
                        close_phase(r);
                    end
                    ST_ARB_LOST:
                    begin
                        r.set_start = 1'b1;
                        r.set_ack = 1'b1;
                        r.clear_interrupt = 1'b1;
                        failed = 1'b1;
                    end
                    ST_SLAR_ACK:
                    begin
                        if (rcv_total <= 8'd1)
                            r.clear_ack = 1'b1;
                        else
                            r.set_ack = 1'b1;
                        r.clear_interrupt = 1'b1;
                    end
                    ST_RXDATA_ACK:
                    begin
                        take_rx(r, it.rx_data);
                        // nack the byte that will be the last one
                        if ({1'b0, rcv_count} + 9'd1 >= {1'b0, rcv_total})
                            r.clear_ack = 1'b1;
                        else
                            r.set_ack = 1'b1;
                        r.clear_interrupt = 1'b1;
                    end
                    ST_RXDATA_NACK:
                    begin
                        take_rx(r, it.rx_data);
                        close_phase(r);
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.busy_res = in_transfer;
        r.result_code = failed;
        return r;
    endfunction

    function automatic item_t rand_item();
        item_t it;
        it.slave_address   = 7'($urandom_range(127));
        it.read_not_write  = 1'($urandom_range(1));
        it.write_then_read = 1'($urandom_range(1));
        it.tx_length       = LEN_W'($urandom_range(32));
        it.rx_length       = 8'($urandom_range(255));
        it.tx_byte         = 8'($urandom_range(255));
        it.status_code     = 8'($urandom_range(255));
        it.rx_data         = 8'($urandom_range(255));
        return it;
    endfunction

    function automatic item_t mk_item(input int addr, input int rnw, input int wtr,
                                      input int txl, input int rxl, input int txb,
                                      input int code, input int data);
        item_t it;
        it.slave_address   = 7'(addr);
        it.read_not_write  = 1'(rnw);
        it.write_then_read = 1'(wtr);
        it.tx_length       = LEN_W'(txl);
        it.rx_length       = 8'(rxl);
        it.tx_byte         = 8'(txb);
        it.status_code     = 8'(code);
        it.rx_data         = 8'(data);
        return it;
    endfunction

    function automatic void add_row(input logic [1:0] mode, input item_t it,
                                    input bit typed = 1'b0, input result_t want = '0);
        stim_row_t row;
        row.mode = mode;
        row.it = it;
        row.typed = typed;
        row.want = want;
        dir_rows.push_back(row);
    endfunction

    task automatic push_word(input logic [1:0] mode, input item_t it,
                             input bit typed = 1'b0, input result_t want = '0);
        item_t   w;
        result_t r;
        bit      counts;
        w = it;
        // never send a store entry that was never loaded
        if (mode == MODE_STATUS && (w.status_code == ST_SLAW_ACK ||
            w.status_code == ST_TXDATA_ACK) && send_pos < send_total &&
            !byte_seen[send_pos[TX_ADDR_W-1:0]])
            w.status_code = ST_TXDATA_NACK;
        if (!src_calm && $urandom_range(99) < 5)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(S_TDATA_W-ITEM_W){1'b0}}, w};
        do @(posedge clk); while (!s_tready);
        if (mode == MODE_LOAD)
            counts = (buf_fill < TX_DEPTH);
        else if (mode == MODE_STATUS)
            counts = is_known_code(w.status_code);
        else
            counts = 1'b1;
        r = predict_word(mode, w);
        expected_q.push_back(typed ? want : r);
        if (counts)
            n_taken++;
    endtask

    task automatic push_status(input logic [7:0] code);
        item_t it;
        it = rand_item();
        it.status_code = code;
        push_word(MODE_STATUS, it);
    endtask

    task automatic push_noise();
        item_t      it;
        logic [1:0] mode;
        logic [7:0] codes [12];
        codes = '{ST_BUS_ERROR, ST_START, ST_RESTART, ST_SLAW_ACK, ST_SLAW_NACK,
                  ST_TXDATA_ACK, ST_TXDATA_NACK, ST_ARB_LOST, ST_SLAR_ACK,
                  ST_SLAR_NACK, ST_RXDATA_ACK, ST_RXDATA_NACK};
        it = rand_item();
        mode = 2'($urandom_range(2));
        if ($urandom_range(9) < 7)
            it.status_code = codes[4'($urandom_range(11))];
        push_word(mode, it);
    endtask

    // kind: 0 write, 1 read, 2 write then read
    task automatic run_transfer(input int kind, input int txl, input int rxl,
                                input int extra_loads, input int rx_cap, input int extra_rx);
        item_t it;
        int    i;
        int    n_ack;
        it = rand_item();
        it.write_then_read = (kind == 2);
        it.read_not_write  = (kind == 1) ? 1'b1 : ((kind == 2) ? it.read_not_write : 1'b0);
        it.tx_length       = LEN_W'(txl);
        it.rx_length       = 8'(rxl);
        push_word(MODE_START, it);
        for (i = 0; i < txl + extra_loads; i++)
            push_word(MODE_LOAD, rand_item());
        push_status(ST_START);
        if ($urandom_range(24) == 0)
        begin
            push_status(ST_ARB_LOST);
            return;
        end
        if (kind != 1)
        begin
            if ($urandom_range(24) == 0)
            begin
                push_status(ST_SLAW_NACK);
                return;
            end
            push_status(ST_SLAW_ACK);
            for (i = 0; i < txl; i++)
            begin
                if ($urandom_range(49) == 0)
                begin
                    push_status(ST_TXDATA_NACK);
                    return;
                end
                push_status(ST_TXDATA_ACK);
            end
            if (kind == 0)
                return;
            push_status(ST_RESTART);
        end
        if ($urandom_range(24) == 0)
        begin
            push_status(ST_SLAR_NACK);
            return;
        end
        push_status(ST_SLAR_ACK);
        n_ack = (rxl == 0) ? 0 : rxl - 1;
        if (n_ack > rx_cap)
            n_ack = rx_cap;
        for (i = 0; i < n_ack + extra_rx; i++)
            push_status(ST_RXDATA_ACK);
        push_status(ST_RXDATA_NACK);
        if ($urandom_range(9) == 0)
            push_status(ST_RXDATA_NACK);
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    // result word monitor
    always @(posedge clk)
    begin : result_mon
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[RESULT_W-1:0];
            if (expected_q.size() == 0)
            begin
                $error("result word with nothing expected");
                err_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                check_field("set_start", want.set_start, got.set_start);
                check_field("set_stop", want.set_stop, got.set_stop);
                check_field("set_ack", want.set_ack, got.set_ack);
                check_field("clear_ack", want.clear_ack, got.clear_ack);
                check_field("clear_interrupt", want.clear_interrupt, got.clear_interrupt);
                check_field("data_write_valid", want.data_write_valid, got.data_write_valid);
                check_field("data_write_byte", want.data_write_byte, got.data_write_byte);
                check_field("rx_valid", want.rx_valid, got.rx_valid);
                check_field("rx_byte", want.rx_byte, got.rx_byte);
                check_field("rx_index", want.rx_index, got.rx_index);
                check_field("busy_res", want.busy_res, got.busy_res);
                check_field("result_code", want.result_code, got.result_code);
                n_results++;
                if (want.rx_valid)
                    n_rx++;
                if (want.result_code)
                    n_nack++;
            end
        end
    end

    // downstream ready, with one long hold-off
    always @(posedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (sink_calm)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(99) >= 12);
    end

    initial
    begin : stimulus
        int t;
        int kind;
        int txl;
        int rxl;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = MODE_START;
        m_tready = 1'b0;

        // directed table
        add_row(MODE_STATUS, mk_item(0, 0, 0, 0, 0, 0, ST_BUS_ERROR, 0), 1'b1,
                '{set_stop: 1'b1, set_ack: 1'b1, clear_interrupt: 1'b1, default: '0});
        add_row(MODE_STATUS, mk_item(0, 0, 0, 0, 0, 0, 8'hFF, 8'hFF), 1'b1, '0);
        add_row(MODE_START, mk_item(127, 0, 1, 2, 2, 0, 0, 0), 1'b1,
                '{set_start: 1'b1, default: '0});
        add_row(MODE_LOAD, mk_item(0, 0, 0, 0, 0, 8'h00, 0, 0), 1'b1, '0);
        add_row(MODE_LOAD, mk_item(0, 0, 0, 0, 0, 8'hFF, 0, 0), 1'b1, '0);
        add_row(MODE_STATUS, mk_item(0, 0, 0, 0, 0, 0, ST_START, 0), 1'b1,
                '{data_write_valid: 1'b1, data_write_byte: 8'hFE, set_ack: 1'b1,
                  clear_interrupt: 1'b1, busy_res: 1'b1, default: '0});
        add_row(MODE_STATUS, mk_item(0, 0, 0, 0, 0, 0, ST_SLAW_ACK, 0));
        add_row(MODE_STATUS, mk_item(0, 0, 0, 0, 0, 0, ST_TXDATA_ACK, 0));
        add_row(MODE_STATUS, mk_item(0, 0, 0, 0, 0, 0, ST_TXDATA_ACK, 0));
        add_row(MODE_STATUS, mk_item(0, 0, 0, 0, 0, 0, ST_RESTART, 0));
        add_row(MODE_STATUS, mk_item(0, 0, 0, 0, 0, 0, ST_SLAR_ACK, 0));
        add_row(MODE_STATUS, mk_item(0, 0, 0, 0, 0, 0, ST_RXDATA_ACK, 8'hA5));
        add_row(MODE_STATUS, mk_item(0, 0, 0, 0, 0, 0, ST_RXDATA_NACK, 8'h5A));
        add_row(MODE_STATUS, mk_item(0, 0, 0, 0, 0, 0, ST_RXDATA_NACK, 8'hFF));
        add_row(MODE_START, mk_item(0, 1, 0, 0, 0, 0, 0, 0));
        add_row(MODE_STATUS, mk_item(0, 0, 0, 0, 0, 0, ST_START, 0));
        add_row(MODE_STATUS, mk_item(0, 0, 0, 0, 0, 0, ST_SLAR_ACK, 0));
        add_row(MODE_STATUS, mk_item(0, 0, 0, 0, 0, 0, ST_SLAR_NACK, 0));
        add_row(MODE_START, mk_item(85, 0, 0, 0, 255, 0, 0, 0));
        add_row(MODE_STATUS, mk_item(0, 0, 0, 0, 0, 0, ST_START, 0));
        add_row(MODE_STATUS, mk_item(0, 0, 0, 0, 0, 0, ST_SLAW_ACK, 0));
        add_row(MODE_STATUS, mk_item(0, 0, 0, 0, 0, 0, ST_SLAW_NACK, 0));
        add_row(MODE_STATUS, mk_item(0, 0, 0, 0, 0, 0, ST_TXDATA_NACK, 0));
        add_row(MODE_STATUS, mk_item(0, 0, 0, 0, 0, 0, ST_ARB_LOST, 0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            push_word(dir_rows[i].mode, dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

        n_taken = 0;
        t = 0;
        while (n_taken < 1600)
        begin
            src_calm  = (t >= 30 && t < 60);
            sink_calm = src_calm;
            if (t == 8)
                hold_req = 90;
            if (t == 20)
            begin
                // let the pipe drain completely
                s_tvalid <= 1'b0;
                while (expected_q.size() != 0) @(posedge clk);
            end
            if (t == 5)
                run_transfer(0, 32, 0, 4, 6, 0);
            else if (t == 40)
                run_transfer(1, 0, 255, 0, 300, 3);
            else if ($urandom_range(4) == 0)
                repeat ($urandom_range(1, 4)) push_noise();
            else
            begin
                kind = $urandom_range(2);
                if ($urandom_range(19) == 0)
                    txl = 32;
                else if ($urandom_range(3) == 0)
                    txl = $urandom_range(32);
                else
                    txl = $urandom_range(4);
                rxl = ($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(5);
                run_transfer(kind, txl, rxl, ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0,
                             6, ($urandom_range(9) == 0) ? 1 : 0);
            end
            t++;
        end

        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("ran %0d directed words and %0d transfers or noise bursts", dir_rows.size(), t);
        $display("checked %0d result words, %0d received bytes, %0d with nack or lost bus",
                 n_results, n_rx, n_nack);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/i2cms_pkg.sv
design/i2cms_tx_ram.sv
design/i2cms_ctrl.sv
design/i2c_master_status_sequencer.sv
tb/tb_i2c_master_status_sequencer.sv
